>>> sv/interval_rank_to_value_core_defines.svh
// Assertion macros for the checker file of the interval rank block.
`ifndef INTERVAL_RANK_TO_VALUE_CORE_DEFINES_SVH
`define INTERVAL_RANK_TO_VALUE_CORE_DEFINES_SVH

// Checks a property on every rising clock edge outside of reset.
`define IRV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define IRV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> sv/irv_pkg.sv
// Package with the function codes of the interval rank block.
package irv_pkg;

  typedef logic [1:0] func_t;

  localparam func_t FUNC_CLEAR  = 2'd0;
  localparam func_t FUNC_APPEND = 2'd1;
  localparam func_t FUNC_QUERY  = 2'd2;

endpackage

>>> sv/irv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module irv_ram #(
  parameter int Width = 20,
  parameter int Depth = 256
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/interval_rank_to_value_core.sv
// Top level of the interval rank block: interval table and rank search sequencer.
//
//  Channel   Direction  Handshake                    Payload
//  command   in         start & !busy accepts        func_i, interval_low_i,
//                                                    interval_high_i, rank_i
//  result    out        done_o, one cycle, no stall  mark_o
//
// A clear or append transaction leaves busy low.
// A query keeps busy high through its binary search steps, each on the single
// read port of the running count memory, and through the final add; done_o
// pulses in the first cycle with busy low again.
// A query with rank zero or above the stored total leaves busy low and gives no result.
// Reset empties the table; the memories themselves are not cleared.
module interval_rank_to_value_core #(
  parameter int MAX_INTERVALS = 256,
  parameter int VALUE_BITS    = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  irv_pkg::func_t        func_i,
  input  logic [VALUE_BITS-1:0] interval_low_i,
  input  logic [VALUE_BITS-1:0] interval_high_i,
  input  logic [VALUE_BITS-1:0] rank_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] mark_o
);
  import irv_pkg::*;

  localparam int IdxW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CntW = $clog2(MAX_INTERVALS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINAL
  } state_e;

  state_e                state_q, state_d;
  logic                  done_q, done_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [VALUE_BITS-1:0] total_q, total_d;
  logic [IdxW-1:0]       left_q, left_d;
  logic [IdxW-1:0]       right_q, right_d;
  logic [IdxW-1:0]       mid_q, mid_d;
  logic [VALUE_BITS-1:0] rank_q, rank_d;
  logic [VALUE_BITS-1:0] mark_q, mark_d;

  logic                  accept;
  logic                  we;
  logic [IdxW-1:0]       waddr;
  logic [IdxW-1:0]       ends_raddr;
  logic [IdxW-1:0]       starts_raddr;
  logic [VALUE_BITS-1:0] ends_rdata;
  logic [VALUE_BITS-1:0] starts_rdata;
  logic [VALUE_BITS:0]   sum_w;
  logic [VALUE_BITS-1:0] sum_sat;
  logic [CntW-1:0]       cnt_m1;
  logic [IdxW-1:0]       init_right;
  logic [IdxW-1:0]       init_mid;
  logic                  go_right;
  logic [IdxW-1:0]       s_left;
  logic [IdxW-1:0]       s_right;
  logic [IdxW-1:0]       s_mid;
  logic [VALUE_BITS-1:0] prev_end;

  assign accept = start && !busy;
  assign waddr  = count_q[IdxW-1:0];

  // Running count of the new entry, saturated to the value range.
  assign sum_w   = {1'b0, total_q} + {1'b0, interval_high_i - interval_low_i}
                 + (VALUE_BITS + 1)'(1);
  assign sum_sat = sum_w[VALUE_BITS] ? {VALUE_BITS{1'b1}} : sum_w[VALUE_BITS-1:0];

  assign cnt_m1     = count_q - CntW'(1);
  assign init_right = cnt_m1[IdxW-1:0];
  assign init_mid   = init_right >> 1;

  // One binary search step on the running count read at mid_q.
  assign go_right = (ends_rdata >= rank_q);
  assign s_left   = go_right ? left_q : mid_q + IdxW'(1);
  assign s_right  = go_right ? mid_q : right_q;
  assign s_mid    = s_left + ((s_right - s_left) >> 1);
  assign prev_end = (left_q == '0) ? '0 : ends_rdata;

  always_comb begin
    state_d      = state_q;
    done_d       = 1'b0;
    count_d      = count_q;
    total_d      = total_q;
    left_d       = left_q;
    right_d      = right_q;
    mid_d        = mid_q;
    rank_d       = rank_q;
    mark_d       = mark_q;
    we           = 1'b0;
    ends_raddr   = mid_q;
    starts_raddr = left_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func_i)
            FUNC_CLEAR: begin
              count_d = '0;
              total_d = '0;
            end
            FUNC_APPEND: begin
              if (interval_high_i >= interval_low_i &&
                  count_q != CntW'(MAX_INTERVALS)) begin
                we      = 1'b1;
                count_d = count_q + CntW'(1);
                total_d = sum_sat;
              end
            end
            FUNC_QUERY: begin
              if (rank_i != '0 && rank_i <= total_q && count_q != '0) begin
                rank_d  = rank_i;
                left_d  = '0;
                right_d = init_right;
                if (init_right == '0) begin
                  starts_raddr = '0;
                  state_d      = ST_FINAL;
                end else begin
                  mid_d      = init_mid;
                  ends_raddr = init_mid;
                  state_d    = ST_SEARCH;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEARCH: begin
        left_d  = s_left;
        right_d = s_right;
        if (s_left < s_right) begin
          mid_d      = s_mid;
          ends_raddr = s_mid;
        end else begin
          // The entry is found: fetch its start and the count before it.
          ends_raddr   = s_left - IdxW'(1);
          starts_raddr = s_left;
          state_d      = ST_FINAL;
        end
      end
      ST_FINAL: begin
        mark_d  = starts_rdata + rank_q - prev_end - VALUE_BITS'(1);
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      count_q <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      count_q <= count_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q  <= left_d;
    right_q <= right_d;
    mid_q   <= mid_d;
    rank_q  <= rank_d;
    mark_q  <= mark_d;
  end

  irv_ram #(
    .Width(VALUE_BITS),
    .Depth(MAX_INTERVALS)
  ) u_starts_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(interval_low_i),
    .raddr_i(starts_raddr),
    .rdata_o(starts_rdata)
  );

  irv_ram #(
    .Width(VALUE_BITS),
    .Depth(MAX_INTERVALS)
  ) u_ends_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(sum_sat),
    .raddr_i(ends_raddr),
    .rdata_o(ends_rdata)
  );

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign mark_o = mark_q;

endmodule

>>> sv/irv_checker.sv
// Port-level checker of the interval rank block and its bind statement.
`include "interval_rank_to_value_core_defines.svh"

module irv_checker #(
  parameter int VALUE_BITS = 20
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input irv_pkg::func_t        func_i,
  input logic [VALUE_BITS-1:0] rank_i,
  input logic                  done_o
);
  import irv_pkg::*;

  // A result only follows the end of a query search.
  `IRV_ASSERT(a_done_after_busy, done_o |-> !busy && $past(busy),
              "result without a finished query")

  // Every finished search delivers a result.
  `IRV_ASSERT(a_fall_gives_done, $fell(busy) |-> done_o, "query ended without a result")

  // Clear and append transactions never start a search nor produce a result.
  `IRV_ASSERT(a_table_ops_quiet,
              start && !busy && func_i != FUNC_QUERY |=> !busy && !done_o,
              "table operation caused activity")

  // A query for rank zero is dropped at once.
  `IRV_ASSERT(a_rank_zero_quiet,
              start && !busy && func_i == FUNC_QUERY && rank_i == '0 |=> !busy && !done_o,
              "rank zero query was not dropped")

  // Reset leaves the block idle and the result strobe low.
  `IRV_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !done_o && !busy, "activity during reset")

endmodule

bind interval_rank_to_value_core irv_checker #(.VALUE_BITS(VALUE_BITS)) u_irv_checker (.*);
